FILE: sv/crpf_pkg.sv
// Package for the Catmull-Rom path follower.
// Holds the beat types, the sequencer states and the fixed widths; no dependencies.
package crpf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_POINTS  = 64;
    localparam int IDX_W       = 6;
    localparam int DUR_W       = 16;
    localparam int PARAM_W     = FRAC_BITS + 1;
    localparam int CNT_W       = 32;
    localparam int PC_W        = 7;
    localparam int COEF_W      = COORD_WIDTH + 5;
    localparam int PROD_W      = COEF_W + PARAM_W;
    localparam int ACC_W       = COORD_WIDTH + 8;
    localparam int NUM_W       = CNT_W + FRAC_BITS;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_LOOP_ENABLE = 1'b1;
    localparam logic FUNC_LOAD       = 1'b0;
    localparam logic FUNC_TICK       = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [IDX_W-1:0]              entry_index;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
        logic [DUR_W-1:0]              duration;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [IDX_W-1:0]              segment;
        logic [PARAM_W-1:0]            path_param;
        logic                          at_end;
    } result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic [DUR_W-1:0]              dur;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DUR, S_DIV, S_UPD, S_SQ, S_CUBE, S_RD0, S_RD1, S_RD2, S_RD3,
        S_MB, S_MC, S_MD, S_ACC
    } state_t;

endpackage

FILE: sv/crpf_mem.sv
// Control point and duration table with one write and one registered read port.
// Depends on crpf_pkg; per-entry valid bits flag unwritten entries through rvalid.
module crpf_mem
    import crpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata,
    output logic             rvalid
);

    entry_t mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] valid_reg;
    entry_t rdata_reg;
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

FILE: sv/crpf_div.sv
// Restoring divider that forms one quotient bit per cycle.
// Depends on crpf_pkg for the numerator and divisor widths.
module crpf_div
    import crpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DUR_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DUR_W:0]   rem_reg;
    logic [NUM_W-1:0] qn_reg;
    logic [DUR_W-1:0] den_reg;
    logic [DUR_W:0]   shifted;
    logic             qbit;

    assign shifted = {rem_reg[DUR_W-1:0], qn_reg[NUM_W-1]};
    assign qbit    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qn_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? (shifted - {1'b0, den_reg}) : shifted;
            qn_reg  <= {qn_reg[NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = qn_reg;

endmodule

FILE: sv/crpf_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on crpf_pkg for the operand widths.
module crpf_mul
    import crpf_pkg::*;
(
    input  logic              clk,
    input  logic [COEF_W-1:0] a,
    input  logic [PARAM_W-1:0] b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

FILE: sv/catmull_rom_path_follower_top.sv
// A load beat is stored in the accept cycle; a tick beat gives its result after the
// bit-serial 48-step divider, the table reads and the shared multiplier passes.
// No new beat is accepted while a tick is at work; busy is high for that time.
// Async reset clears segment, count, end and loop flags, t, valid bits; sets point count 4.
// The receiver cannot stall: done is high for one cycle with the result beat.
module catmull_rom_path_follower_top
    import crpf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cmd_t            cmd,
    output logic            done,
    output result_t         result,
    input  logic            cfg_we,
    input  logic            cfg_addr,
    input  logic [PC_W-1:0] cfg_wdata
);

    localparam logic [PARAM_W-1:0] ONE_T = PARAM_W'(1) << FRAC_BITS;

    state_t state_reg, state_next;

    logic [PC_W-1:0]  pc_reg;
    logic             loop_reg;
    logic [IDX_W-1:0] seg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             end_reg;
    logic [PARAM_W-1:0] t_reg, t2_reg, t3_reg;
    logic [1:0]       axis_reg;
    logic             done_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [DUR_W-1:0] dur_sel;
    logic signed [COORD_WIDTH-1:0] p_reg [4][3];
    logic signed [COORD_WIDTH-1:0] pos_reg [3];

    logic             accept;
    logic             mem_we;
    entry_t           wdata, rdata;
    logic             rvalid;
    logic [IDX_W-1:0] raddr;
    logic             div_start, div_done;
    logic [NUM_W-1:0] quot;
    logic [COEF_W-1:0] mul_a;
    logic [PARAM_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;

    logic [PC_W-1:0]  n_pts, last;
    logic             clamp_hi, clamp_lo;
    logic [IDX_W-1:0] caddr;
    logic signed [COEF_W-1:0] cp0, cp1, cp2, cp3, ca, cb, cc, cd, csel, cterm;
    logic [COEF_W-1:0] cmag;
    logic [ACC_W-1:0] tmag, term, acc_sum;
    logic signed [ACC_W-1:0] half;
    logic signed [COORD_WIDTH-1:0] sat;

    assign accept = start && (state_reg == S_IDLE);
    assign mem_we = accept && (cmd.func == FUNC_LOAD);
    assign wdata  = '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z, dur: cmd.duration};
    assign dur_sel = (rvalid && rdata.dur != '0) ? rdata.dur : DUR_W'(1);

    crpf_mem u_mem (
        .clk(clk), .rst_n(rst_n), .we(mem_we), .waddr(cmd.entry_index), .wdata(wdata),
        .raddr(raddr), .rdata(rdata), .rvalid(rvalid)
    );

    crpf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num({cnt_reg, {FRAC_BITS{1'b0}}}),
        .den(dur_sel), .done(div_done), .quot(quot)
    );

    crpf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

    always_comb
    begin
        n_pts = pc_reg;
        if (pc_reg < PC_W'(4))
        begin
            n_pts = PC_W'(4);
        end
        else if (pc_reg > PC_W'(MAX_POINTS))
        begin
            n_pts = PC_W'(MAX_POINTS);
        end
        last     = n_pts - PC_W'(2);
        clamp_hi = {1'b0, seg_reg} > last;
        clamp_lo = (seg_reg == '0);
        caddr    = clamp_hi ? last[IDX_W-1:0] : IDX_W'(1);
    end

    always_comb
    begin
        cp0   = COEF_W'(p_reg[0][axis_reg]);
        cp1   = COEF_W'(p_reg[1][axis_reg]);
        cp2   = COEF_W'(p_reg[2][axis_reg]);
        cp3   = COEF_W'(p_reg[3][axis_reg]);
        ca    = cp1 <<< 1;
        cb    = cp2 - cp0;
        cc    = (cp0 <<< 1) - (cp1 <<< 2) - cp1 + (cp2 <<< 2) - cp3;
        cd    = -cp0 + (cp1 <<< 1) + cp1 - (cp2 <<< 1) - cp2 + cp3;
        case (state_reg)
            S_MB:    csel = cb;
            S_MC:    csel = cc;
            default: csel = cd;
        endcase
        cmag  = csel[COEF_W-1] ? COEF_W'(-csel) : COEF_W'(csel);
        case (state_reg)
            S_MC:    cterm = cb;
            S_MD:    cterm = cc;
            default: cterm = cd;
        endcase
        tmag  = ACC_W'(prod[PROD_W-1:FRAC_BITS]);
        term  = cterm[COEF_W-1] ? -tmag : tmag;
        acc_sum = acc_reg + term;
        half  = $signed(acc_sum) >>> 1;
        if (half > $signed(ACC_W'({1'b0, {(COORD_WIDTH-1){1'b1}}})))
        begin
            sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (half < -$signed(ACC_W'({1'b1, {(COORD_WIDTH-1){1'b0}}})))
        begin
            sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat = half[COORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && (cmd.func == FUNC_TICK)) state_next = S_DUR;
            S_DUR:   state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_UPD;
            S_UPD:   state_next = S_SQ;
            S_SQ:    state_next = S_CUBE;
            S_CUBE:  state_next = S_RD0;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_MB;
            S_MB:    state_next = S_MC;
            S_MC:    state_next = S_MD;
            S_MD:    state_next = S_ACC;
            S_ACC:   state_next = (axis_reg == 2'd2) ? S_IDLE : S_MB;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = t_reg;
        raddr     = seg_reg;
        case (state_reg)
            S_DUR:   div_start = 1'b1;
            S_SQ:    mul_a = COEF_W'(t_reg);
            S_CUBE:
            begin
                mul_a = COEF_W'(prod[FRAC_BITS +: PARAM_W]);
                raddr = (clamp_hi || clamp_lo) ? caddr : seg_reg - 1'b1;
            end
            S_RD0:   raddr = (clamp_hi || clamp_lo) ? caddr : seg_reg;
            S_RD1:   raddr = (clamp_hi || clamp_lo) ? caddr : seg_reg + 1'b1;
            S_RD2:   raddr = (clamp_hi || clamp_lo) ? caddr : seg_reg + 2'd2;
            S_MB:    mul_a = cmag;
            S_MC:
            begin
                mul_a = cmag;
                mul_b = t2_reg;
            end
            S_MD:
            begin
                mul_a = cmag;
                mul_b = t3_reg;
            end
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CUBE:  t2_reg <= prod[FRAC_BITS +: PARAM_W];
            S_RD0:
            begin
                t3_reg <= prod[FRAC_BITS +: PARAM_W];
                p_reg[0][0] <= rdata.x;
                p_reg[0][1] <= rdata.y;
                p_reg[0][2] <= rdata.z;
            end
            S_RD1:
            begin
                p_reg[1][0] <= rdata.x;
                p_reg[1][1] <= rdata.y;
                p_reg[1][2] <= rdata.z;
            end
            S_RD2:
            begin
                p_reg[2][0] <= rdata.x;
                p_reg[2][1] <= rdata.y;
                p_reg[2][2] <= rdata.z;
            end
            S_RD3:
            begin
                p_reg[3][0] <= rdata.x;
                p_reg[3][1] <= rdata.y;
                p_reg[3][2] <= rdata.z;
            end
            S_MC:    acc_reg <= ACC_W'(ca) + term;
            S_MD:    acc_reg <= acc_sum;
            S_ACC:   pos_reg[axis_reg] <= (clamp_hi || clamp_lo) ? p_reg[1][axis_reg] : sat;
            default: acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_W'(4);
            loop_reg  <= 1'b0;
            seg_reg   <= '0;
            cnt_reg   <= '0;
            end_reg   <= 1'b0;
            t_reg     <= '0;
            axis_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_ACC) && (axis_reg == 2'd2);
            if (cfg_we)
            begin
                if (cfg_addr == CFG_POINT_COUNT)
                begin
                    pc_reg <= cfg_wdata;
                end
                else
                begin
                    loop_reg <= cfg_wdata[0];
                end
            end
            if (accept && (cmd.func == FUNC_TICK) && (cnt_reg != '1))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_UPD)
            begin
                axis_reg <= '0;
                if (quot[NUM_W-1:FRAC_BITS] != '0)
                begin
                    if ({1'b0, seg_reg} < n_pts - PC_W'(3))
                    begin
                        seg_reg <= seg_reg + 1'b1;
                        cnt_reg <= '0;
                        t_reg   <= (quot[NUM_W-1:PARAM_W] != '0) ? ONE_T :
                                   quot[PARAM_W-1:0] - ONE_T;
                    end
                    else
                    begin
                        if (loop_reg)
                        begin
                            seg_reg <= '0;
                        end
                        end_reg <= 1'b1;
                        t_reg   <= ONE_T;
                    end
                end
                else
                begin
                    t_reg <= quot[PARAM_W-1:0];
                end
            end
            if (state_reg == S_ACC)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = '{pos_x: pos_reg[0], pos_y: pos_reg[1], pos_z: pos_reg[2],
                      segment: seg_reg, path_param: t_reg, at_end: end_reg};

endmodule

FILE: sv/crpf_checker.sv
// Port-level checker for the path follower, bound to the top level.
// Depends on crpf_pkg and the top level's ports.
module crpf_checker
    import crpf_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input cmd_t            cmd,
    input logic            done,
    input result_t         result,
    input logic            cfg_we,
    input logic            cfg_addr,
    input logic [PC_W-1:0] cfg_wdata
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result beat lasted more than one cycle");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == FUNC_TICK) |=> busy)
        else $error("tick beat did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.path_param <= (PARAM_W'(1) << FRAC_BITS)))
        else $error("path parameter above one");

endmodule

bind catmull_rom_path_follower_top crpf_checker u_crpf_checker (.*);

FILE: tb/sv/catmull_rom_path_follower_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for catmull_rom_path_follower_top: loads control points,
// sends tick beats and compares every result with a built-in spline predictor.
// Depends on crpf_pkg and the top-level module only.
module catmull_rom_path_follower_top_tb;
    import crpf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 90;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    result_t result;
    logic cfg_we;
    logic cfg_addr;
    logic [PC_W-1:0] cfg_wdata;

    catmull_rom_path_follower_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    cmd_t pending_cmds[$];
    result_t expected_points[$];

    logic signed [COORD_WIDTH-1:0] point_mem[3][MAX_POINTS];
    logic [DUR_W-1:0] dur_mem[MAX_POINTS];
    logic [IDX_W-1:0] seg_idx;
    logic [CNT_W-1:0] tick_cnt;
    logic end_seen;
    logic [PC_W-1:0] pts_in_use;
    logic loop_on;

    int cycles;
    int errors;
    int gap;
    int n_ticks;
    int n_loads;
    int n_points_checked;
    bit taken;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint frac_mul(longint coef, longint t);
        longint m;
        longint r;
        m = (coef < 0) ? -coef : coef;
        r = (m * t) >>> FRAC_BITS;
        return (coef < 0) ? -r : r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] spline_point(int axis, int n, int seg,
                                                                longint t, longint t2,
                                                                longint t3);
        longint p0;
        longint p1;
        longint p2;
        longint p3;
        longint s;
        longint h;
        if (seg > n - 2)
            return point_mem[axis][n-2];
        if (seg < 1)
            return point_mem[axis][1];
        p0 = point_mem[axis][seg-1];
        p1 = point_mem[axis][seg];
        p2 = point_mem[axis][seg+1];
        p3 = point_mem[axis][seg+2];
        s = 2 * p1 + frac_mul(p2 - p0, t)
            + frac_mul(2 * p0 - 5 * p1 + 4 * p2 - p3, t2)
            + frac_mul(-p0 + 3 * p1 - 3 * p2 + p3, t3);
        h = s >>> 1;
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        if (h < -64'sd2147483648)
            h = -64'sd2147483648;
        return h[COORD_WIDTH-1:0];
    endfunction

    function automatic result_t advance_tick();
        result_t r;
        int n;
        int seg;
        longint dur;
        longint q;
        longint t;
        longint t2;
        longint t3;
        longint one;
        one = longint'(1) << FRAC_BITS;
        n = int'(pts_in_use);
        if (n < 4)
            n = 4;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        seg = int'(seg_idx);
        dur = longint'(dur_mem[seg]);
        if (dur == 0)
            dur = 1;
        if (tick_cnt != '1)
            tick_cnt = tick_cnt + 1'b1;
        q = (longint'(tick_cnt) << FRAC_BITS) / dur;
        if (q >= one)
        begin
            if (seg < n - 3)
            begin
                seg_idx = IDX_W'(seg + 1);
                t = q - one;
                if (t > one)
                    t = one;
                tick_cnt = '0;
            end
            else
            begin
                if (loop_on)
                    seg_idx = '0;
                end_seen = 1'b1;
                t = one;
            end
        end
        else
            t = q;
        t2 = (t * t) >>> FRAC_BITS;
        t3 = (t2 * t) >>> FRAC_BITS;
        seg = int'(seg_idx);
        r.pos_x = spline_point(0, n, seg, t, t2, t3);
        r.pos_y = spline_point(1, n, seg, t, t2, t3);
        r.pos_z = spline_point(2, n, seg, t, t2, t3);
        r.segment = seg_idx;
        r.path_param = t[PARAM_W-1:0];
        r.at_end = end_seen;
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
        taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_POINT_COUNT)
                    pts_in_use = cfg_wdata;
                else
                    loop_on = cfg_wdata[0];
            end
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    n_points_checked++;
                    if (result.pos_x !== want.pos_x || result.pos_y !== want.pos_y ||
                        result.pos_z !== want.pos_z || result.segment !== want.segment ||
                        result.path_param !== want.path_param ||
                        result.at_end !== want.at_end)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                taken = 1'b1;
                if (cmd.func == FUNC_TICK)
                begin
                    n_ticks++;
                    expected_points = {expected_points, advance_tick()};
                end
                else
                begin
                    n_loads++;
                    point_mem[0][cmd.entry_index] = cmd.coord_x;
                    point_mem[1][cmd.entry_index] = cmd.coord_y;
                    point_mem[2][cmd.entry_index] = cmd.coord_z;
                    dur_mem[cmd.entry_index] = cmd.duration;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (gap > 0)
            begin
                gap <= gap - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                if ($urandom_range(0, 9) < 6)
                    gap <= 0;
                else if ($urandom_range(0, 9) < 8)
                    gap <= $urandom_range(1, 4);
                else
                    gap <= $urandom_range(20, 120);
            end
            else
                start <= 1'b0;
        end
    end

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic cmd_t make_load(int idx, int max_dur);
        cmd_t c;
        c.func = FUNC_LOAD;
        c.entry_index = IDX_W'(idx);
        c.coord_x = pick_coord();
        c.coord_y = pick_coord();
        c.coord_z = pick_coord();
        if ($urandom_range(0, 39) == 0)
            c.duration = 16'hFFFF;
        else
            c.duration = DUR_W'($urandom_range(0, max_dur));
        return c;
    endfunction

    function automatic cmd_t make_tick();
        cmd_t c;
        c = '0;
        c.func = FUNC_TICK;
        c.entry_index = IDX_W'($urandom);
        c.coord_x = $urandom;
        c.coord_y = $urandom;
        c.coord_z = $urandom;
        c.duration = DUR_W'($urandom);
        return c;
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || expected_points.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [PC_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cmd_t c;
        int pc_list[7];
        int lp_list[7];
        int n_use;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_POINT_COUNT;
        cfg_wdata = '0;
        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        gap = 0;
        n_ticks = 0;
        n_loads = 0;
        n_points_checked = 0;
        seg_idx = '0;
        tick_cnt = '0;
        end_seen = 1'b0;
        pts_in_use = 4;
        loop_on = 1'b0;
        foreach (dur_mem[i])
            dur_mem[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner points first, then the rest of the table so no tick reads a blank entry.
        c = '0;
        c.func = FUNC_LOAD;
        c.coord_x = 32'sh7FFFFFFF;
        c.coord_y = 32'sh80000000;
        c.coord_z = 32'sh7FFFFFFF;
        c.duration = 16'h0000;
        pending_cmds = {pending_cmds, c};
        c.entry_index = 1;
        c.coord_x = 32'sh80000000;
        c.coord_y = 32'sh7FFFFFFF;
        c.coord_z = '0;
        c.duration = 16'hFFFF;
        pending_cmds = {pending_cmds, c};
        c.entry_index = 2;
        c.coord_x = 32'sh7FFFFFFF;
        c.coord_y = 32'sh80000000;
        c.coord_z = -1;
        c.duration = 16'h0003;
        pending_cmds = {pending_cmds, c};
        for (int i = 3; i < MAX_POINTS; i++)
            pending_cmds = {pending_cmds, make_load(i, 6)};
        repeat (8) pending_cmds = {pending_cmds, make_tick()};
        c = make_load(1, 2);
        pending_cmds = {pending_cmds, c};
        repeat (6) pending_cmds = {pending_cmds, make_tick()};
        drain();

        pc_list = '{4, 64, 127, 0, 5, 9, 0};
        lp_list = '{0, 1, 1, 0, 1, 0, 1};
        pc_list[6] = $urandom_range(6, 63);
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(CFG_POINT_COUNT, PC_W'(pc_list[ph]));
            write_reg(CFG_LOOP_ENABLE, lp_list[ph] ? 7'h7F : 7'h00);
            n_use = pc_list[ph] < 4 ? 4 : (pc_list[ph] > MAX_POINTS ? MAX_POINTS : pc_list[ph]);
            for (int k = 0; k < 90; k++)
            begin
                if ($urandom_range(0, 9) < 8)
                    pending_cmds = {pending_cmds, make_tick()};
                else
                    pending_cmds = {pending_cmds, make_load($urandom_range(0, n_use - 1), 5)};
            end
            drain();
        end

        $display("Covered %0d load beats and %0d tick beats over 8 register settings;",
                 n_loads, n_ticks);
        $display("%0d interpolated points checked, %0d errors.", n_points_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
